### rtl/fsot_pkg.sv
// ----------------------------------------------------------------------------
// fsot_pkg: shared types and constants of the first-free slot owner table
// Codes, port widths and the control and token structs of the row cells.
// ----------------------------------------------------------------------------
package fsot_pkg;

  // port widths fixed by the transaction format
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned OWN_W    = 16;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 11;

  // defaults of the top-level parameters
  localparam int unsigned SLOT_DEPTH_DEF = 1024;
  localparam int unsigned OWNER_BITS_DEF = 16;

  // occupancy row width, one row per cell
  localparam int unsigned ROW_W = 32;
  localparam int unsigned ROW_LSB_W = 5;
  // row number width carried between cells, enough for the largest table
  localparam int unsigned CELL_ROW_W = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESERVE = 2'd0,
    FN_RELEASE = 2'd1,
    FN_QUERY   = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_OWNER = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FREE      = 3'd4
  } status_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  clear;
    logic [CFG_W-1:0]      cap;
    logic                  upd_en;
    logic [CELL_ROW_W-1:0] upd_row;
    logic                  upd_full;
  } cell_ctrl_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [CELL_ROW_W-1:0] row;
  } tok_t;

endpackage

### rtl/first_free_slot_owner_table_unit.sv
// ----------------------------------------------------------------------------
// first_free_slot_owner_table_unit: first-fit slot allocator with owner tags
// Owner store and occupancy bitmap in memories, a row of cells that finds the
// lowest row with a free slot, and a controller that serves one transaction.
// ----------------------------------------------------------------------------
// flow: a reserve walks a search token down the cells (one cell a cycle) and
//   then writes the picked row, release and query read the memories first,
//   rejected requests go straight to the result; one transaction is in work
//   at a time and the next is taken in the cycle after the result is loaded
// reset, and any capacity write in range, start a clearing pass over the NROW
//   (SLOT_DEPTH / 32 rounded up) bitmap rows, one row a cycle, with in_ready_o low
// ----------------------------------------------------------------------------
module first_free_slot_owner_table_unit #(
  parameter int unsigned SLOT_DEPTH = fsot_pkg::SLOT_DEPTH_DEF,
  parameter int unsigned OWNER_BITS = fsot_pkg::OWNER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsot_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fsot_pkg::FUNC_W-1:0]   func_i,
  input  logic [fsot_pkg::OWN_W-1:0]    owner_id_i,
  input  logic [fsot_pkg::IDX_W-1:0]    slot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsot_pkg::STATUS_W-1:0] status_o,
  output logic [fsot_pkg::IDX_W-1:0]    result_slot_o,
  output logic [fsot_pkg::OWN_W-1:0]    result_owner_o,
  output logic [fsot_pkg::CFG_W-1:0]    taken_now_o,
  output logic [fsot_pkg::CFG_W-1:0]    free_now_o
);
  import fsot_pkg::*;

  localparam int unsigned NRow    = (SLOT_DEPTH + ROW_W - 1) / ROW_W;
  localparam int unsigned RowIw   = (NRow > 1) ? $clog2(NRow) : 1;
  localparam int unsigned SlotIw  = $clog2(SLOT_DEPTH);
  localparam int unsigned CapReset = (SLOT_DEPTH < 1024) ? SLOT_DEPTH : 1024;
  localparam int unsigned OwnKeep = (OWNER_BITS < OWN_W) ? OWNER_BITS : OWN_W;
  localparam logic [OWN_W-1:0] OwnHiMask = ~({OWN_W{1'b1}} >> (OWN_W - OwnKeep));
  localparam int unsigned CmpW = (RowIw + ROW_LSB_W + 1 > CFG_W + 1) ?
                                 RowIw + ROW_LSB_W + 1 : CFG_W + 1;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_PICK   = 6'b001000,
    S_EXEC   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [RowIw-1:0]  clr_row_q, clr_row_d;
  logic              clr_start_q, clr_start_d;
  logic [CFG_W-1:0]  cap_q, cap_d;
  logic [CFG_W-1:0]  taken_q, taken_d;
  logic              search_go_q, search_go_d;

  logic [FUNC_W-1:0] req_func_q;
  logic [OWN_W-1:0]  req_owner_q;
  logic [IDX_W-1:0]  req_idx_q;
  logic [RowIw-1:0]  pick_row_q, pick_row_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]  res_slot_q, res_slot_d;
  logic [OWN_W-1:0]  res_owner_q, res_owner_d;

  logic              out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [IDX_W-1:0]  out_slot_q;
  logic [OWN_W-1:0]  out_owner_q;
  logic [CFG_W-1:0]  out_taken_q, out_free_q;
  logic              out_load;

  // memories
  logic [ROW_W-1:0]      occ_mem [NRow];
  logic [OWNER_BITS-1:0] own_mem [SLOT_DEPTH];
  logic                  occ_we;
  logic [RowIw-1:0]      occ_wa, occ_ra;
  logic [ROW_W-1:0]      occ_wd, occ_rd_q;
  logic                  own_we;
  logic [SlotIw-1:0]     own_wa, own_ra;
  logic [OWNER_BITS-1:0] own_wd, own_rd_q;

  // cell chain
  cell_ctrl_t ctrl;
  tok_t       chain [NRow+1];

  logic       accept;
  logic       cfg_ok;
  logic [ROW_W-1:0] clr_mask;
  logic [ROW_LSB_W-1:0] free_pos;
  logic [ROW_W-1:0] free_bit, req_bit;
  logic       slot_taken;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_ok     = cfg_we_i && (cfg_wdata_i != '0) && (32'(cfg_wdata_i) <= SLOT_DEPTH);

  // out-of-capacity slots of the row being cleared read as taken
  always_comb begin
    logic [CmpW-1:0] base;
    logic [CmpW-1:0] capx;
    logic [CmpW-1:0] span;
    base = CmpW'({clr_row_q, {ROW_LSB_W{1'b0}}});
    capx = CmpW'(cap_q);
    span = capx - base;
    if (base >= capx) begin
      clr_mask = '1;
    end else if (span >= CmpW'(ROW_W)) begin
      clr_mask = '0;
    end else begin
      clr_mask = ~((ROW_W'(1) << span[ROW_LSB_W-1:0]) - ROW_W'(1));
    end
  end

  // lowest free slot of the fetched row
  always_comb begin
    free_pos = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!occ_rd_q[b]) begin
        free_pos = ROW_LSB_W'(b);
      end
    end
  end

  assign free_bit   = ROW_W'(1) << free_pos;
  assign req_bit    = ROW_W'(1) << req_idx_q[ROW_LSB_W-1:0];
  assign slot_taken = occ_rd_q[req_idx_q[ROW_LSB_W-1:0]];

  always_comb begin
    state_d      = state_q;
    clr_row_d    = clr_row_q;
    clr_start_d  = 1'b0;
    cap_d        = cap_q;
    taken_d      = taken_q;
    search_go_d  = 1'b0;
    pick_row_d   = pick_row_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_owner_d  = res_owner_q;
    out_load     = 1'b0;
    occ_we       = 1'b0;
    occ_wa       = clr_row_q;
    occ_wd       = clr_mask;
    own_we       = 1'b0;
    own_wa       = SlotIw'({pick_row_q, free_pos});
    own_wd       = OWNER_BITS'(req_owner_q);
    ctrl.clear    = clr_start_q;
    ctrl.cap      = cap_q;
    ctrl.upd_en   = 1'b0;
    ctrl.upd_row  = CELL_ROW_W'(pick_row_q);
    ctrl.upd_full = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        occ_we = 1'b1;
        if (clr_row_q == RowIw'(NRow - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_row_d = clr_row_q + RowIw'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_slot_d  = slot_index_i;
          res_owner_d = '0;
          unique case (func_i)
            FN_RESERVE: begin
              if (taken_q >= cap_q) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else if ((owner_id_i == '0) || ((owner_id_i & OwnHiMask) != '0)) begin
                res_status_d = ST_BAD_OWNER;
                state_d      = S_DONE;
              end else begin
                search_go_d = 1'b1;
                state_d     = S_SEARCH;
              end
            end
            FN_RELEASE, FN_QUERY: begin
              if (CFG_W'(slot_index_i) >= cap_q) begin
                res_status_d = ST_RANGE;
                state_d      = S_DONE;
              end else begin
                state_d = S_EXEC;
              end
            end
            default: begin
              res_status_d = ST_OK;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (chain[NRow].valid) begin
          if (chain[NRow].hit) begin
            pick_row_d = RowIw'(chain[NRow].row);
            state_d    = S_PICK;
          end else begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end
        end
      end
      S_PICK: begin
        occ_we        = 1'b1;
        occ_wa        = pick_row_q;
        occ_wd        = occ_rd_q | free_bit;
        own_we        = 1'b1;
        ctrl.upd_en   = 1'b1;
        ctrl.upd_full = &(occ_rd_q | free_bit);
        taken_d       = taken_q + CFG_W'(1);
        res_status_d  = ST_OK;
        res_slot_d    = IDX_W'({pick_row_q, free_pos});
        res_owner_d   = req_owner_q;
        state_d       = S_DONE;
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (req_func_q == FN_QUERY) begin
          res_status_d = ST_OK;
          res_owner_d  = slot_taken ? OWN_W'(own_rd_q) : '0;
        end else if (!slot_taken) begin
          res_status_d = ST_FREE;
          res_owner_d  = '0;
        end else begin
          res_status_d  = ST_OK;
          res_owner_d   = OWN_W'(own_rd_q);
          occ_we        = 1'b1;
          occ_wa        = RowIw'(req_idx_q >> ROW_LSB_W);
          occ_wd        = occ_rd_q & ~req_bit;
          ctrl.upd_en   = 1'b1;
          ctrl.upd_row  = CELL_ROW_W'(req_idx_q >> ROW_LSB_W);
          ctrl.upd_full = 1'b0;
          if (taken_q != '0) begin
            taken_d = taken_q - CFG_W'(1);
          end
        end
      end
      S_DONE: begin
        // hold until the previous result has left the output register
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    if (cfg_ok) begin
      cap_d       = cfg_wdata_i;
      taken_d     = '0;
      clr_row_d   = '0;
      clr_start_d = 1'b1;
      state_d     = S_CLEAR;
    end
  end

  assign occ_ra = (state_q == S_SEARCH) ? RowIw'(chain[NRow].row)
                                        : RowIw'(slot_index_i >> ROW_LSB_W);
  assign own_ra = SlotIw'(slot_index_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_row_q   <= '0;
      clr_start_q <= 1'b1;
      cap_q       <= CFG_W'(CapReset);
      taken_q     <= '0;
      search_go_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      clr_start_q <= clr_start_d;
      cap_q       <= cap_d;
      taken_q     <= taken_d;
      search_go_q <= search_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_func_q  <= func_i;
      req_owner_q <= owner_id_i;
      req_idx_q   <= slot_index_i;
    end
    pick_row_q   <= pick_row_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_owner_q  <= res_owner_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_owner_q  <= res_owner_q;
      out_taken_q  <= taken_q;
      out_free_q   <= cap_q - taken_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_rd_q <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    own_rd_q <= own_mem[own_ra];
  end

  // search token enters at row zero and leaves after the last row
  assign chain[0].valid = search_go_q;
  assign chain[0].hit   = 1'b0;
  assign chain[0].row   = '0;

  for (genvar r = 0; r < NRow; r++) begin : g_cell
    fsot_cell #(
      .CELL_INDEX(r)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .tok_i (chain[r]),
      .tok_o (chain[r+1])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_slot_o  = out_slot_q;
  assign result_owner_o = out_owner_q;
  assign taken_now_o    = out_taken_q;
  assign free_now_o     = out_free_q;

endmodule

### rtl/fsot_cell.sv
// ----------------------------------------------------------------------------
// fsot_cell: one row cell of the slot table search chain
// Holds the full flag of one occupancy row and passes the search token on,
// claiming it when the row still has a free slot.
// ----------------------------------------------------------------------------
module fsot_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsot_pkg::cell_ctrl_t ctrl_i,
  input  fsot_pkg::tok_t      tok_i,
  output fsot_pkg::tok_t      tok_o
);
  import fsot_pkg::*;

  localparam int unsigned CellBase = CELL_INDEX * ROW_W;

  logic full_q, full_d;
  tok_t tok_q, tok_d;

  always_comb begin
    full_d = full_q;
    if (ctrl_i.clear) begin
      // rows wholly beyond the capacity never take a slot
      full_d = (32'(ctrl_i.cap) <= 32'(CellBase));
    end else if (ctrl_i.upd_en && (ctrl_i.upd_row == CELL_ROW_W'(CELL_INDEX))) begin
      full_d = ctrl_i.upd_full;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.hit && !full_q) begin
      tok_d.hit = 1'b1;
      tok_d.row = CELL_ROW_W'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b1;
      tok_q  <= '0;
    end else begin
      full_q <= full_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
